[rtl/mtdc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mtdc_pkg - shared constants, types and tables for the magnitude mapper
// Holds the fixed-point widths, register codes, the log2 mantissa ROM and
// the 3-3-2 heat colormap table, all built at elaboration.
// ============================================================================
package mtdc_pkg;

    // Input format and log table size
    localparam int MAG_WIDTH      = 32;
    localparam int MAG_FRAC_BITS  = 16;
    localparam int LOG_TABLE_BITS = 8;
    localparam int LOG_ENTRIES    = 1 << LOG_TABLE_BITS;
    localparam int POS_W          = $clog2(MAG_WIDTH);

    // log2 in signed Q.16
    localparam int LOG_FRAC = 16;
    localparam int LOG_W    = $clog2(MAG_WIDTH + MAG_FRAC_BITS) + LOG_FRAC + 1;

    // round(2^16 * 20*log10(2)), held signed with one spare sign bit
    localparam int DB_K   = 394566;
    localparam int DB_K_W = 20;
    localparam logic signed [DB_K_W-1:0] DB_K_S = DB_K_W'(DB_K);

    // Register widths
    localparam int OFFSET_W    = 10;
    localparam int SLOPE_W     = 16;
    localparam int MODE_W      = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    // Level arithmetic: level held in Q.40
    localparam int LEVEL_FRAC = 40;
    localparam int PROD1_W    = LOG_W + DB_K_W;
    localparam int PROD2_W    = PROD1_W + SLOPE_W + 1;
    localparam int SUM_W      = PROD2_W + 1;
    localparam int LEVEL_W    = 8;
    localparam int PIXEL_W    = 8;

    // Valid stages from input register to result register
    localparam int PIPE_DEPTH = 7;

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_OFFSET = 2'd0,
        REG_DB_SLOPE    = 2'd1,
        REG_COLOR_MODE  = 2'd2
    } cfg_reg_t;

    // Colour modes; the unused code falls back to grayscale
    typedef enum logic [MODE_W-1:0] {
        MODE_GRAY    = 2'd0,
        MODE_INVERSE = 2'd1,
        MODE_HEAT    = 2'd2
    } color_mode_t;

    // Register reset values
    localparam logic signed [OFFSET_W-1:0] GAIN_OFFSET_RST = 10'sd100;
    localparam logic [SLOPE_W-1:0]         DB_SLOPE_RST    = 16'd544;
    localparam logic [MODE_W-1:0]          COLOR_MODE_RST  = MODE_HEAT;

    // Load enables for the stages behind the input register
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } stage_en_t;

    typedef logic [LOG_FRAC-1:0] log_rom_t [LOG_ENTRIES];
    typedef logic [PIXEL_W-1:0]  heat_tab_t [1 << LEVEL_W];

    // floor(2^16 * log2(1 + i/2^LOG_TABLE_BITS)) by repeated squaring in Q1.30
    function automatic log_rom_t gen_log_rom();
        log_rom_t               rom;
        logic [63:0]            y;
        logic [LOG_FRAC-1:0]    frac;
        for (int i = 0; i < LOG_ENTRIES; i++)
        begin
            y    = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
            frac = '0;
            for (int n = 0; n < LOG_FRAC; n++)
            begin
                y    = (y * y) >> 30;
                frac = {frac[LOG_FRAC-2:0], 1'b0};
                if (y >= (64'd1 << 31))
                begin
                    y       = y >> 1;
                    frac[0] = 1'b1;
                end
            end
            rom[i] = frac;
        end
        return rom;
    endfunction

    // Heat ramps: red and green rise late, blue rises then falls then rises
    function automatic heat_tab_t gen_heat_tab();
        heat_tab_t tab;
        int        r;
        int        g;
        int        b;
        int        num;
        for (int k = 0; k < (1 << LEVEL_W); k++)
        begin
            num = 40 * k - 2040;
            r   = (num < 0) ? 0 : num / 255;
            if (r > 7)
                r = 7;
            num = 40 * k - 6120;
            g   = (num < 0) ? 0 : num / 255;
            if (g > 7)
                g = 7;
            if (k <= 102)
                b = (4 * k) / 51;
            else if (k <= 204)
            begin
                num = 612 - 4 * k;
                b   = (num <= 0) ? 0 : num / 51;
            end
            else
                b = (4 * k - 816) / 51;
            if (b > 3)
                b = 3;
            tab[k] = {3'(r), 3'(g), 2'(b)};
        end
        return tab;
    endfunction

    localparam log_rom_t  LOG_ROM  = gen_log_rom();
    localparam heat_tab_t HEAT_TAB = gen_heat_tab();

endpackage
`default_nettype wire

[rtl/mtdc_log.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mtdc_log - fixed-point log2 of the magnitude
// Stage one finds the leading one; stage two normalises the bits below it,
// looks up the mantissa ROM and forms log2 in signed Q.16.
// ============================================================================
module mtdc_log (
    input  logic                            clk,
    input  mtdc_pkg::stage_en_t             en,
    input  logic [mtdc_pkg::MAG_WIDTH-1:0]  mag,
    output logic [mtdc_pkg::LOG_W-1:0]      lg,
    output logic                            zero
);
    import mtdc_pkg::*;

    logic [POS_W-1:0]                  pos_next;
    logic [POS_W-1:0]                  pos_reg;
    logic [MAG_WIDTH-1:0]              mant_reg;
    logic                              z1_reg;
    logic [MAG_WIDTH+LOG_TABLE_BITS-1:0] norm;
    logic [LOG_TABLE_BITS-1:0]         idx;
    logic [LOG_W-1:0]                  lg_next;
    logic [LOG_W-1:0]                  lg_reg;
    logic                              z2_reg;

    // Find the leading-one position
    always_comb
    begin
        pos_next = '0;
        for (int i = 0; i < MAG_WIDTH; i++)
        begin
            if (mag[i])
                pos_next = POS_W'(i);
        end
    end

    // Hold position, magnitude and zero flag
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            pos_reg  <= pos_next;
            mant_reg <= mag;
            z1_reg   <= (mag == '0);
        end
    end

    // Take the table bits just below the leading one
    assign norm = {mant_reg, {LOG_TABLE_BITS{1'b0}}} >> pos_reg;
    assign idx  = norm[LOG_TABLE_BITS-1:0];

    // Integer part from the position, fraction from the ROM
    assign lg_next = (LOG_W'(pos_reg) << LOG_FRAC)
                   - (LOG_W'(MAG_FRAC_BITS) << LOG_FRAC)
                   + LOG_W'(LOG_ROM[idx]);

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            lg_reg <= lg_next;
            z2_reg <= z1_reg;
        end
    end

    assign lg   = lg_reg;
    assign zero = z2_reg;

endmodule
`default_nettype wire

[rtl/mtdc_scale.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mtdc_scale - decibel and slope scaling
// Two registered multiplies: log2 by 20*log10(2) in Q.16, then by the
// Q8.8 slope, giving the scaled level in Q.40.
// ============================================================================
module mtdc_scale (
    input  logic                                    clk,
    input  mtdc_pkg::stage_en_t                     en,
    input  logic [mtdc_pkg::LOG_W-1:0]              lg,
    input  logic                                    zero_in,
    input  logic [mtdc_pkg::SLOPE_W-1:0]            slope,
    output logic signed [mtdc_pkg::PROD2_W-1:0]     prod,
    output logic                                    zero_out
);
    import mtdc_pkg::*;

    logic signed [PROD1_W-1:0] p1_next;
    logic signed [PROD1_W-1:0] p1_reg;
    logic                      z3_reg;
    logic signed [PROD2_W-1:0] p2_next;
    logic signed [PROD2_W-1:0] p2_reg;
    logic                      z4_reg;

    // Convert log2 to decibels
    assign p1_next = PROD1_W'($signed(lg)) * PROD1_W'(DB_K_S);

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            p1_reg <= p1_next;
            z3_reg <= zero_in;
        end
    end

    // Apply intensity per decibel
    assign p2_next = PROD2_W'(p1_reg) * PROD2_W'($signed({1'b0, slope}));

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            p2_reg <= p2_next;
            z4_reg <= z3_reg;
        end
    end

    assign prod     = p2_reg;
    assign zero_out = z4_reg;

endmodule
`default_nettype wire

[rtl/mtdc_map.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mtdc_map - level clamp and colour mapping
// Adds the offset, clamps the level to 0..255, then renders it as gray,
// inverse gray or the 3-3-2 heat colormap into the result register.
// ============================================================================
module mtdc_map (
    input  logic                                    clk,
    input  mtdc_pkg::stage_en_t                     en,
    input  logic signed [mtdc_pkg::PROD2_W-1:0]     prod,
    input  logic                                    zero,
    input  logic signed [mtdc_pkg::OFFSET_W-1:0]    offset,
    input  logic [mtdc_pkg::MODE_W-1:0]             mode,
    output logic [mtdc_pkg::PIXEL_W-1:0]            pixel,
    output logic [mtdc_pkg::LEVEL_W-1:0]            level
);
    import mtdc_pkg::*;

    logic signed [SUM_W-1:0]         sum;
    logic [SUM_W-2-LEVEL_FRAC:0]     whole;
    logic [LEVEL_W-1:0]              level_next;
    logic [LEVEL_W-1:0]              level_reg;
    logic [PIXEL_W-1:0]              pixel_next;
    logic [PIXEL_W-1:0]              pixel_reg;
    logic [LEVEL_W-1:0]              level_out_reg;

    // Add the offset in Q.40
    assign sum   = SUM_W'(prod) + (SUM_W'(offset) <<< LEVEL_FRAC);
    assign whole = sum[SUM_W-2:LEVEL_FRAC];

    // Clamp to the 8-bit level; zero magnitude forces black
    always_comb
    begin
        priority if (zero || sum[SUM_W-1])
            level_next = '0;
        else if (|whole[SUM_W-2-LEVEL_FRAC:LEVEL_W])
            level_next = '1;
        else
            level_next = whole[LEVEL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.s5)
            level_reg <= level_next;
    end

    // Render the level in the selected mode
    always_comb
    begin
        unique case (mode)
            MODE_INVERSE: pixel_next = ~level_reg;
            MODE_HEAT:    pixel_next = HEAT_TAB[level_reg];
            default:      pixel_next = level_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.s6)
        begin
            pixel_reg     <= pixel_next;
            level_out_reg <= level_reg;
        end
    end

    assign pixel = pixel_reg;
    assign level = level_out_reg;

endmodule
`default_nettype wire

[rtl/magnitude_to_db_colormap_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// magnitude_to_db_colormap_unit - spectrogram magnitude to display pixel
// Log2 by leading one and ROM, scaled to dB and by the slope, offset and
// clamped to a level, then shown as gray, inverse gray or RGB 3-3-2 heat.
// ============================================================================
//
//  Channel  Handshake              Payload
//  -------  ---------------------  ------------------------------------
//  cfg      cfg_wr_en              cfg_index, cfg_data
//  in       in_valid / in_stall    magnitude
//  out      out_valid / out_stall  pixel, level
//
//  One beat per cycle while out_stall is low; a beat passes through each stage
//  in turn to the output. Seven register stages: input register, leading one,
//  ROM lookup, two multiplies, clamp, map.
//  Each stage loads when empty or when the stage after it moves, so
//  in_stall rises only when all seven stages hold a beat and out_stall is high.
//  Reset empties the pipeline and restores the configuration registers.
//
module magnitude_to_db_colormap_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [mtdc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mtdc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [mtdc_pkg::MAG_WIDTH-1:0]      magnitude,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [mtdc_pkg::PIXEL_W-1:0]        pixel,
    output logic [mtdc_pkg::LEVEL_W-1:0]        level
);
    import mtdc_pkg::*;

    logic signed [OFFSET_W-1:0] gain_offset_reg;
    logic [SLOPE_W-1:0]         db_slope_reg;
    logic [MODE_W-1:0]          color_mode_reg;
    logic [PIPE_DEPTH-1:0]      vld_reg;
    logic [PIPE_DEPTH-1:0]      vld_next;
    logic [PIPE_DEPTH-1:0]      ld;
    logic [MAG_WIDTH-1:0]       mag_reg;
    stage_en_t                  en;
    logic [LOG_W-1:0]           lg;
    logic                       lg_zero;
    logic signed [PROD2_W-1:0]  prod;
    logic                       prod_zero;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_offset_reg <= GAIN_OFFSET_RST;
            db_slope_reg    <= DB_SLOPE_RST;
            color_mode_reg  <= COLOR_MODE_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_GAIN_OFFSET: gain_offset_reg <= $signed(cfg_data[OFFSET_W-1:0]);
                REG_DB_SLOPE:    db_slope_reg    <= cfg_data[SLOPE_W-1:0];
                REG_COLOR_MODE:  color_mode_reg  <= cfg_data[MODE_W-1:0];
                default:         ;
            endcase
        end
    end

    // Load a stage when it is empty or its beat moves on
    always_comb
    begin
        ld[PIPE_DEPTH-1] = !vld_reg[PIPE_DEPTH-1] || !out_stall;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--)
            ld[i] = !vld_reg[i] || ld[i+1];
    end

    // Advance the valid bits
    always_comb
    begin
        vld_next[0] = ld[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < PIPE_DEPTH; i++)
            vld_next[i] = ld[i] ? vld_reg[i-1] : vld_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (ld[0])
            mag_reg <= magnitude;
    end

    assign en.s1 = ld[1];
    assign en.s2 = ld[2];
    assign en.s3 = ld[3];
    assign en.s4 = ld[4];
    assign en.s5 = ld[5];
    assign en.s6 = ld[6];

    mtdc_log u_log (
        .clk  (clk),
        .en   (en),
        .mag  (mag_reg),
        .lg   (lg),
        .zero (lg_zero)
    );

    mtdc_scale u_scale (
        .clk      (clk),
        .en       (en),
        .lg       (lg),
        .zero_in  (lg_zero),
        .slope    (db_slope_reg),
        .prod     (prod),
        .zero_out (prod_zero)
    );

    mtdc_map u_map (
        .clk    (clk),
        .en     (en),
        .prod   (prod),
        .zero   (prod_zero),
        .offset (gain_offset_reg),
        .mode   (color_mode_reg),
        .pixel  (pixel),
        .level  (level)
    );

    assign in_stall  = !ld[0];
    assign out_valid = vld_reg[PIPE_DEPTH-1];

    // Input back-pressure only with every stage occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&vld_reg))
        else $error("input stalled with an empty stage");

    // A free output never holds off the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while the output drains");

    // A new result comes only from the clamp stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(vld_reg[PIPE_DEPTH-2]))
        else $error("result appeared without a beat behind it");

endmodule
`default_nettype wire

[sim/mtdc_pixel_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// mtdc_pixel_checker - result checker for the magnitude to pixel mapper
// Follows register writes, predicts level and pixel for every magnitude
// accepted on the input channel, and compares each beat leaving the output
// channel, in order, against the oldest prediction still outstanding.
// ============================================================================
module mtdc_pixel_checker
    import mtdc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [MAG_WIDTH-1:0]    magnitude,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [PIXEL_W-1:0]      pixel,
    input  logic [LEVEL_W-1:0]      level,
    output int                      pending_beats,
    output int                      fail_count
);

    // 20*log10(2) in Q.16, and the level's fraction width
    localparam longint DB_SCALE   = 394566;
    localparam int     LEVEL_SHIFT = 40;

    typedef struct packed {
        logic [MAG_WIDTH-1:0] mag;
        logic [PIXEL_W-1:0]   pixel;
        logic [LEVEL_W-1:0]   level;
    } db_pixel_t;

    logic signed [OFFSET_W-1:0] offset_q;
    logic [SLOPE_W-1:0]         slope_q;
    logic [MODE_W-1:0]          mode_q;
    logic [LOG_FRAC-1:0]        log2_frac [LOG_ENTRIES];
    db_pixel_t                  expected_pixels [$];
    db_pixel_t                  want;
    int                         bad;

    // Build the mantissa log table: square a Q1.30 value, one fraction bit per round
    initial
    begin
        logic [63:0]         y;
        logic [LOG_FRAC-1:0] frac;
        for (int i = 0; i < LOG_ENTRIES; i++)
        begin
            y    = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
            frac = '0;
            for (int n = 0; n < LOG_FRAC; n++)
            begin
                y    = (y * y) >> 30;
                frac = frac << 1;
                if (y >= (64'd1 << 31))
                begin
                    y       = y >> 1;
                    frac[0] = 1'b1;
                end
            end
            log2_frac[i] = frac;
        end
    end

    // Predict level and pixel for one magnitude under the current registers
    function automatic db_pixel_t predict_beat(input logic [MAG_WIDTH-1:0] m);
        db_pixel_t                 res;
        int                        p;
        logic [LOG_TABLE_BITS-1:0] idx;
        longint                    lg;
        longint                    s;
        int                        k;
        int                        r;
        int                        g;
        int                        b;
        res.mag = m;
        k       = 0;
        if (m != '0)
        begin
            p = MAG_WIDTH - 1;
            while (p > 0 && !m[p])
                p--;
            if (p >= LOG_TABLE_BITS)
                idx = LOG_TABLE_BITS'(m >> (p - LOG_TABLE_BITS));
            else
                idx = LOG_TABLE_BITS'(m << (LOG_TABLE_BITS - p));
            lg = longint'(p - MAG_FRAC_BITS) * 65536 + longint'(log2_frac[idx]);
            s  = lg * DB_SCALE * longint'(slope_q)
               + longint'(offset_q) * (longint'(1) << LEVEL_SHIFT);
            if (s >= 0)
            begin
                s = s >>> LEVEL_SHIFT;
                k = (s > 255) ? 255 : int'(s);
            end
        end
        res.level = LEVEL_W'(k);

        // Heat ramps: red and green rise late, blue rises, falls, rises again
        r = (40 * k - 2040 < 0) ? 0 : (40 * k - 2040) / 255;
        g = (40 * k - 6120 < 0) ? 0 : (40 * k - 6120) / 255;
        if (k <= 102)
            b = (4 * k) / 51;
        else if (k <= 204)
            b = (612 - 4 * k <= 0) ? 0 : (612 - 4 * k) / 51;
        else
            b = (4 * k - 816) / 51;
        if (r > 7)
            r = 7;
        if (g > 7)
            g = 7;
        if (b > 3)
            b = 3;

        // Spare selector code shows grey like mode zero
        if (mode_q == MODE_INVERSE)
            res.pixel = PIXEL_W'(255 - k);
        else if (mode_q == MODE_HEAT)
            res.pixel = {3'(r), 3'(g), 2'(b)};
        else
            res.pixel = PIXEL_W'(k);
        return res;
    endfunction

    // Track registers, queue predictions, compare departing beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_q      <= GAIN_OFFSET_RST;
            slope_q       <= DB_SLOPE_RST;
            mode_q        <= COLOR_MODE_RST;
            expected_pixels.delete();
            pending_beats <= 0;
            fail_count    <= 0;
        end
        else
        begin
            bad = 0;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_GAIN_OFFSET: offset_q <= cfg_data[OFFSET_W-1:0];
                    REG_DB_SLOPE:    slope_q  <= cfg_data[SLOPE_W-1:0];
                    REG_COLOR_MODE:  mode_q   <= cfg_data[MODE_W-1:0];
                    default:         ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: beat with nothing outstanding: expected none, actual pixel %0d level %0d",
                             $time, pixel, level);
                    bad++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel !== want.pixel)
                    begin
                        $display("%0t: pixel mismatch for magnitude %h: expected %0d actual %0d",
                                 $time, want.mag, want.pixel, pixel);
                        bad++;
                    end
                    if (level !== want.level)
                    begin
                        $display("%0t: level mismatch for magnitude %h: expected %0d actual %0d",
                                 $time, want.mag, want.level, level);
                        bad++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_pixels.push_back(predict_beat(magnitude));
            pending_beats <= expected_pixels.size();
            fail_count    <= fail_count + bad;
        end
    end

endmodule

[sim/tb_magnitude_to_db_colormap_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_magnitude_to_db_colormap_unit - testbench for the magnitude mapper
// Drives directed edge magnitudes and then random log-spread magnitudes over
// several register settings, with bursty input and a varying output stall;
// the checker beside the block predicts and compares every beat.
// ============================================================================
module tb_magnitude_to_db_colormap_unit;
    import mtdc_pkg::*;

    localparam logic [MODE_W-1:0]      MODE_SPARE     = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE      = 2'd3;
    localparam int                     WATCHDOG_LIMIT = 2000;
    localparam int                     PHASES         = 8;
    localparam int                     PHASE_ITEMS    = 56;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [MAG_WIDTH-1:0]   magnitude;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [PIXEL_W-1:0]     pixel;
    logic [LEVEL_W-1:0]     level;
    int                     pending_beats;
    int                     fail_count;

    bit                     sender_gaps;
    int                     burst_left;
    int                     cycle_no = 0;
    int                     stall_style = 0;
    int                     stall_hold = 0;
    int                     idle_cycles = 0;

    logic [MAG_WIDTH-1:0] reset_cfg_mags [12] = '{
        32'h0000_0000, 32'h0000_0001, 32'h0000_0003, 32'h0000_00FF,
        32'h0000_01FF, 32'h0001_0000, 32'h0001_8000, 32'h00FF_FFFF,
        32'h8000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555
    };
    logic [MAG_WIDTH-1:0] flat_slope_mags [4] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000
    };
    logic [MAG_WIDTH-1:0] steep_slope_mags [5] = '{
        32'h0001_0000, 32'h0002_0000, 32'h0000_FFFF, 32'h0001_0100, 32'hFFFF_FFFF
    };
    logic [MODE_W-1:0] mode_cycle [4] = '{MODE_GRAY, MODE_INVERSE, MODE_HEAT, MODE_SPARE};

    always #2 clk = ~clk;

    magnitude_to_db_colormap_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .magnitude (magnitude),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel     (pixel),
        .level     (level)
    );

    mtdc_pixel_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .magnitude     (magnitude),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel         (pixel),
        .level         (level),
        .pending_beats (pending_beats),
        .fail_count    (fail_count)
    );

    // Output stall: drive one of four patterns, chosen at random
    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if (cycle_no % 96 == 0)
            stall_style <= $urandom_range(0, 3);
        case (stall_style)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= (cycle_no % 5 < 2);
            default:
            begin
                if (stall_hold > 0)
                begin
                    out_stall  <= 1'b1;
                    stall_hold <= stall_hold - 1;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    out_stall  <= 1'b1;
                    stall_hold <= $urandom_range(3, 12);
                end
                else
                    out_stall <= 1'b0;
            end
        endcase
    end

    // Watchdog: give up after too long without any beat moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_magnitude_to_db_colormap_unit failed");
            $finish;
        end
    end

    // Present one magnitude, with a random gap at the end of each burst
    task automatic push_magnitude(input logic [MAG_WIDTH-1:0] m);
        if (sender_gaps && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        in_valid  <= 1'b1;
        magnitude <= m;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
    endtask

    // Drain the pipeline, then write all registers plus the spare index
    task automatic configure(input logic [OFFSET_W-1:0] off, input logic [SLOPE_W-1:0] slope,
                             input logic [MODE_W-1:0] mode);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_beats != 0)
            @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_GAIN_OFFSET;
        cfg_data  <= {junk[15:10], off};
        @(posedge clk);
        cfg_index <= REG_DB_SLOPE;
        cfg_data  <= slope;
        @(posedge clk);
        cfg_index <= REG_COLOR_MODE;
        cfg_data  <= {junk[13:0], mode};
        @(posedge clk);
        cfg_index <= REG_SPARE;
        cfg_data  <= junk;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        burst_left = 0;
    endtask

    // Mostly log-spread magnitudes, plus zero, raw words and edge patterns
    function automatic logic [MAG_WIDTH-1:0] rand_magnitude();
        int                   sel;
        int                   p;
        logic [MAG_WIDTH-1:0] m;
        sel = $urandom_range(0, 19);
        m   = $urandom;
        if (sel == 0)
            m = '0;
        else if (sel == 1)
            m = ($urandom_range(0, 1) == 0) ? '1 : (32'd1 << $urandom_range(0, 31));
        else if (sel > 2)
        begin
            p = $urandom_range(0, MAG_WIDTH - 1);
            m = (m & ((32'd1 << p) - 32'd1)) | (32'd1 << p);
        end
        return m;
    endfunction

    initial
    begin
        logic [SLOPE_W-1:0] slope_pick;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_GAIN_OFFSET;
        cfg_data    = '0;
        in_valid    = 1'b0;
        magnitude   = '0;
        sender_gaps = 1'b0;
        burst_left  = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: heat map, edge magnitudes back to back
        foreach (reset_cfg_mags[i])
            push_magnitude(reset_cfg_mags[i]);

        // Flat slope, top offset, inverse grey
        configure(10'h1FF, 16'd0, MODE_INVERSE);
        foreach (flat_slope_mags[i])
            push_magnitude(flat_slope_mags[i]);

        // Steepest slope, bottom offset, spare selector
        configure(10'h200, 16'hFFFF, MODE_SPARE);
        foreach (steep_slope_mags[i])
            push_magnitude(steep_slope_mags[i]);

        // Random phases across settings and idling styles
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case ($urandom_range(0, 7))
                0:       slope_pick = 16'hFFFF;
                1:       slope_pick = 16'd0;
                2:       slope_pick = SLOPE_W'($urandom);
                default: slope_pick = SLOPE_W'($urandom_range(128, 1024));
            endcase
            configure(OFFSET_W'($urandom_range(0, 1023)), slope_pick, mode_cycle[ph % 4]);
            sender_gaps = (ph % 3) != 0;
            repeat (PHASE_ITEMS)
                push_magnitude(rand_magnitude());
        end

        // Wait out outstanding beats, then wait for strays
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_beats != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
        if (fail_count == 0)
            $display("tb_magnitude_to_db_colormap_unit passed");
        else
            $display("tb_magnitude_to_db_colormap_unit failed");
        $finish;
    end

endmodule

[files.f]
rtl/mtdc_pkg.sv
rtl/mtdc_log.sv
rtl/mtdc_scale.sv
rtl/mtdc_map.sv
rtl/magnitude_to_db_colormap_unit.sv
sim/mtdc_pixel_checker.sv
sim/tb_magnitude_to_db_colormap_unit.sv
